// ----- rtl/core/rrs_pkg.sv -----
`default_nettype none

package rrs_pkg;

  // Input and output field widths
  localparam int unsigned RND_W    = 8;
  localparam int unsigned OV_IN_W  = 3;
  localparam int unsigned CHOSEN_W = 3;

  // Tasks kept per overlay
  localparam int unsigned TASKS  = 3;
  localparam int unsigned TASK_W = 2;

  localparam logic [TASK_W-1:0] TASK_RECTIFY  = 2'd1;
  localparam logic [TASK_W-1:0] TASK_ATTEST   = 2'd2;
  localparam logic [TASK_W-1:0] TASK_CNT_FULL = TASK_W'(TASKS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_OV_RD,
    ST_OV_CHK,
    ST_TK_RD,
    ST_TK_UPD,
    ST_OUT
  } state_e;

  // One word of the per-overlay task memory
  typedef struct packed {
    logic              turn;
    logic [TASK_W-1:0] cnt;
    logic [TASKS-1:0]  used;
  } task_ent_t;

  localparam task_ent_t TASK_ENT_RESET = '{turn: 1'b1, cnt: '0, used: '0};

endpackage

`default_nettype wire

// ----- rtl/core/rrs_rem.sv -----
`default_nettype none

// Remainders: random byte mod OVERLAYS, random byte mod 3, overlay index
// mod OVERLAYS. Stage one: quotient by reciprocal multiply. Stage two:
// x - q * d. x * ceil(2^16 / d) >> 16 is exact for 8-bit x, d up to 64.
module rrs_rem #(
  parameter int unsigned OVERLAYS = 8,
  localparam int unsigned IdxW = (OVERLAYS > 1) ? $clog2(OVERLAYS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rrs_pkg::RND_W-1:0]     rnd_i,
  input  wire logic [rrs_pkg::OV_IN_W-1:0]   ov_i,
  output logic                               done_o,
  output logic [IdxW-1:0]                    rem_rnd_o,
  output logic [IdxW-1:0]                    rem_ov_o,
  output logic [rrs_pkg::TASK_W-1:0]         rem3_o
);

  localparam int unsigned RecipS = 16;
  localparam int unsigned ProdW  = rrs_pkg::RND_W + RecipS + 1;
  localparam logic [ProdW-1:0] OvRecip =
    ProdW'(((1 << RecipS) + OVERLAYS - 1) / OVERLAYS);
  localparam logic [ProdW-1:0] TriRecip =
    ProdW'(((1 << RecipS) + rrs_pkg::TASKS - 1) / rrs_pkg::TASKS);
  localparam logic [15:0] OvD  = 16'(OVERLAYS);
  localparam logic [15:0] TriD = 16'(rrs_pkg::TASKS);

  logic                        s1_q, done_q;
  logic [rrs_pkg::RND_W-1:0]   rnd_q, ov_q, qr_q, qo_q, q3_q;
  logic [IdxW-1:0]             rr_q, ro_q;
  logic [rrs_pkg::TASK_W-1:0]  r3_q;

  logic [ProdW-1:0] prod_rnd, prod_ov, prod3;
  logic [15:0]      dr, dov, d3;

  assign prod_rnd = ProdW'(rnd_i) * OvRecip;
  assign prod_ov  = ProdW'(ov_i) * OvRecip;
  assign prod3    = ProdW'(rnd_i) * TriRecip;

  assign dr  = 16'(rnd_q) - 16'(qr_q) * OvD;
  assign dov = 16'(ov_q) - 16'(qo_q) * OvD;
  assign d3  = 16'(rnd_q) - 16'(q3_q) * TriD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      done_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rnd_q <= rnd_i;
      ov_q  <= (rrs_pkg::RND_W)'(ov_i);
      qr_q  <= prod_rnd[RecipS +: rrs_pkg::RND_W];
      qo_q  <= prod_ov[RecipS +: rrs_pkg::RND_W];
      q3_q  <= prod3[RecipS +: rrs_pkg::RND_W];
    end
    if (s1_q) begin
      rr_q <= dr[IdxW-1:0];
      ro_q <= dov[IdxW-1:0];
      r3_q <= d3[rrs_pkg::TASK_W-1:0];
    end
  end

  assign done_o    = done_q;
  assign rem_rnd_o = rr_q;
  assign rem_ov_o  = ro_q;
  assign rem3_o    = r3_q;

endmodule

`default_nettype wire

// ----- rtl/core/randomized_round_scheduler.sv -----
// Randomized round scheduler: random-order round robin without repeats.
// Input channel (in_valid_i / in_ready_o) carries one pick request: action_i
// selects an overlay pick (0) or a task pick for overlay_i (1); random_byte_i
// is the probe start; attest_done_i, attest_lost_i and rectify_new_i steer the
// task overrides. Output channel (out_valid_o / out_ready_i) returns one
// chosen_o per request, in order.
// Flow: a request is taken only in idle. The start points come from a
// two-stage remainder unit (reciprocal multiply, then multiply and subtract).
// An overlay pick then probes the used-mark memory with one synchronous read
// and one check per slot, p = 1..OVERLAYS slots; a task pick does one
// read-modify-write of the task memory. A new request is taken only after
// the result of the last one has gone to the output register.
// Output register: a finished result waits there while the receiver stalls,
// and the next request is accepted meanwhile; a second finished result holds
// the block in its output state until the register frees up.
// Reset: valid bits of both memories clear (tasks read as all free with the
// rectify turn set), round count and epoch clear. No clearing pass is needed.
`default_nettype none

module randomized_round_scheduler #(
  parameter int unsigned OVERLAYS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [rrs_pkg::RND_W-1:0]     random_byte_i,
  input  wire logic [rrs_pkg::OV_IN_W-1:0]   overlay_i,
  input  wire logic                          attest_done_i,
  input  wire logic                          attest_lost_i,
  input  wire logic                          rectify_new_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rrs_pkg::CHOSEN_W-1:0]       chosen_o
);

  localparam int unsigned IdxW = (OVERLAYS > 1) ? $clog2(OVERLAYS) : 1;
  localparam int unsigned CntW = $clog2(OVERLAYS + 1);
  localparam int unsigned XW   = (IdxW > rrs_pkg::CHOSEN_W) ? IdxW : rrs_pkg::CHOSEN_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(OVERLAYS - 1);
  localparam logic [CntW-1:0] RoundFull = CntW'(OVERLAYS);

  // Request fields kept for the duration of the pick
  logic action_q, attest_done_q, attest_lost_q, rectify_new_q;
  logic in_xfer;

  // Remainder unit
  logic                        rem_done;
  logic [IdxW-1:0]             rem_rnd, rem_ov;
  logic [rrs_pkg::TASK_W-1:0]  rem3;

  // Control
  rrs_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] pos_q, pos_d, k_q, k_d, pos_nx, fin_pos;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic            epoch_q, epoch_d;
  logic [rrs_pkg::CHOSEN_W-1:0] res_q, res_d, chosen_q, chosen_d;
  logic            out_valid_q, out_valid_d;
  logic [XW-1:0]   pos_x;

  // Overlay used-mark memory: stores the epoch of the round that marked it
  logic            ovl_mem [OVERLAYS];
  logic [OVERLAYS-1:0] ovl_vld_q;
  logic            ovl_rd_q, ovl_rd_vld_q, ovl_we, ovl_used;

  // Task memory: per-overlay used bits, count and rectify turn
  rrs_pkg::task_ent_t tk_mem [OVERLAYS];
  logic [OVERLAYS-1:0] tk_vld_q;
  rrs_pkg::task_ent_t tk_rd_q, tk_ent, tk_wr;
  logic            tk_rd_vld_q, tk_we, tk_forced, tk_mark;
  logic [rrs_pkg::TASK_W-1:0] tk_pick, p1, p2;

  function automatic logic [rrs_pkg::TASK_W-1:0] next_task(
    input logic [rrs_pkg::TASK_W-1:0] t
  );
    next_task = (t == rrs_pkg::TASK_ATTEST) ? '0 : t + 2'd1;
  endfunction

  assign in_xfer = in_valid_i && in_ready_o;

  rrs_rem #(
    .OVERLAYS(OVERLAYS)
  ) u_rem (
    .clk_i,
    .rst_ni,
    .start_i   (in_xfer),
    .rnd_i     (random_byte_i),
    .ov_i      (overlay_i),
    .done_o    (rem_done),
    .rem_rnd_o (rem_rnd),
    .rem_ov_o  (rem_ov),
    .rem3_o    (rem3)
  );

  // Overlay probe helpers
  assign ovl_used = ovl_rd_vld_q && (ovl_rd_q == epoch_q);
  assign pos_nx   = (pos_q == LastIdx) ? '0 : pos_q + IdxW'(1);
  assign fin_pos  = ovl_used ? rem_rnd : pos_q;  // all used: back to start
  assign pos_x    = XW'(fin_pos);

  // Task read-modify-write
  always_comb begin
    tk_ent = tk_rd_vld_q ? tk_rd_q : rrs_pkg::TASK_ENT_RESET;
    if (tk_ent.cnt >= rrs_pkg::TASK_CNT_FULL) begin
      tk_ent.cnt  = '0;
      tk_ent.used = '0;
    end
    tk_wr     = tk_ent;
    tk_forced = 1'b1;
    p1        = next_task(rem3);
    p2        = next_task(p1);
    if (!attest_done_q && attest_lost_q) begin
      tk_pick = rrs_pkg::TASK_ATTEST;
    end else if (rectify_new_q && tk_ent.turn) begin
      tk_wr.turn = 1'b0;
      tk_pick    = rrs_pkg::TASK_RECTIFY;
    end else begin
      tk_wr.turn = 1'b1;
      tk_forced  = 1'b0;
      if (!tk_ent.used[rem3]) begin
        tk_pick = rem3;
      end else if (!tk_ent.used[p1]) begin
        tk_pick = p1;
      end else if (!tk_ent.used[p2]) begin
        tk_pick = p2;
      end else begin
        tk_pick = rem3;
      end
    end
    // forced picks count only when the task was still free
    tk_mark = !tk_forced || !tk_ent.used[tk_pick];
    if (tk_mark) begin
      tk_wr.cnt           = tk_ent.cnt + 2'd1;
      tk_wr.used[tk_pick] = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    k_d         = k_q;
    ocnt_d      = ocnt_q;
    epoch_d     = epoch_q;
    res_d       = res_q;
    chosen_d    = chosen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ovl_we      = 1'b0;
    tk_we       = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      rrs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = rrs_pkg::ST_MOD;
        end
      end
      rrs_pkg::ST_MOD: begin
        if (rem_done) begin
          if (!action_q) begin
            // full round: drop all marks by moving to a new epoch
            if (ocnt_q >= RoundFull) begin
              ocnt_d  = '0;
              epoch_d = !epoch_q;
            end
            pos_d   = rem_rnd;
            k_d     = '0;
            state_d = rrs_pkg::ST_OV_RD;
          end else begin
            state_d = rrs_pkg::ST_TK_RD;
          end
        end
      end
      rrs_pkg::ST_OV_RD: begin
        state_d = rrs_pkg::ST_OV_CHK;
      end
      rrs_pkg::ST_OV_CHK: begin
        if (!ovl_used || (k_q == LastIdx)) begin
          ovl_we  = 1'b1;
          ocnt_d  = ocnt_q + CntW'(1);
          res_d   = pos_x[rrs_pkg::CHOSEN_W-1:0];
          state_d = rrs_pkg::ST_OUT;
        end else begin
          pos_d   = pos_nx;
          k_d     = k_q + IdxW'(1);
          state_d = rrs_pkg::ST_OV_RD;
        end
      end
      rrs_pkg::ST_TK_RD: begin
        state_d = rrs_pkg::ST_TK_UPD;
      end
      rrs_pkg::ST_TK_UPD: begin
        tk_we   = 1'b1;
        res_d   = rrs_pkg::CHOSEN_W'(tk_pick);
        state_d = rrs_pkg::ST_OUT;
      end
      rrs_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          chosen_d    = res_q;
          state_d     = rrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrs_pkg::ST_IDLE;
      ocnt_q      <= '0;
      epoch_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ovl_vld_q   <= '0;
      tk_vld_q    <= '0;
    end else begin
      state_q     <= state_d;
      ocnt_q      <= ocnt_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
      if (ovl_we) begin
        ovl_vld_q[fin_pos] <= 1'b1;
      end
      if (tk_we) begin
        tk_vld_q[rem_ov] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q      <= action_i;
      attest_done_q <= attest_done_i;
      attest_lost_q <= attest_lost_i;
      rectify_new_q <= rectify_new_i;
    end
    pos_q    <= pos_d;
    k_q      <= k_d;
    res_q    <= res_d;
    chosen_q <= chosen_d;
  end

  // Memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (ovl_we) begin
      ovl_mem[fin_pos] <= epoch_q;
    end
    ovl_rd_q     <= ovl_mem[pos_q];
    ovl_rd_vld_q <= ovl_vld_q[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      tk_mem[rem_ov] <= tk_wr;
    end
    tk_rd_q     <= tk_mem[rem_ov];
    tk_rd_vld_q <= tk_vld_q[rem_ov];
  end

  assign out_valid_o = out_valid_q;
  assign chosen_o    = chosen_q;

endmodule

`default_nettype wire

// ----- rtl/core/rrs_checker.sv -----
`default_nettype none

module rrs_assert (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] chosen_o
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Requests taken whose result is not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_o))
    else $error("result changed or dropped while stalled");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("request taken while a pick is in progress");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without an outstanding request");

  a_idle_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> pend_q <= 2'd1)
    else $error("idle with more than one result outstanding");

endmodule

bind randomized_round_scheduler rrs_assert u_rrs_assert (.*);

`default_nettype wire

// ----- bench/rrs_tb_pkg.sv -----
`timescale 1ns / 100ps

package rrs_tb_pkg;

  // Request kind carried on action_i
  typedef enum logic {
    PICK_OVERLAY = 1'b0,
    PICK_TASK    = 1'b1
  } pick_kind_e;

endpackage

// ----- bench/rrs_checker.sv -----
`timescale 1ns / 100ps

module rrs_checker #(
  parameter int unsigned OVERLAYS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          action_i,
  input  logic [rrs_pkg::RND_W-1:0]     random_byte_i,
  input  logic [rrs_pkg::OV_IN_W-1:0]   overlay_i,
  input  logic                          attest_done_i,
  input  logic                          attest_lost_i,
  input  logic                          rectify_new_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [rrs_pkg::CHOSEN_W-1:0]  chosen_i,
  output int                            err_cnt_o,
  output int                            pending_o
);
  import rrs_pkg::*;
  import rrs_tb_pkg::*;

  // Mirror of the scheduler rounds
  logic             ov_used [OVERLAYS];
  int unsigned      ov_round_cnt;
  logic [TASKS-1:0] tk_used [OVERLAYS];
  int unsigned      tk_round_cnt [OVERLAYS];
  logic             tk_turn [OVERLAYS];

  logic [CHOSEN_W-1:0] chosen_q [$];
  logic [CHOSEN_W-1:0] chosen_exp;

  function automatic int unsigned next_overlay(logic [RND_W-1:0] rnd);
    int unsigned slot;
    int unsigned k;
    if (ov_round_cnt >= OVERLAYS) begin
      ov_round_cnt = 0;
      foreach (ov_used[i]) ov_used[i] = 1'b0;
    end
    slot = rnd % OVERLAYS;
    for (k = 0; k < OVERLAYS && ov_used[slot]; k++) slot = (slot + 1) % OVERLAYS;
    if (k == OVERLAYS) slot = rnd % OVERLAYS;
    ov_round_cnt++;
    ov_used[slot] = 1'b1;
    return slot;
  endfunction

  // Forced task: marked and counted only while still free
  function automatic void claim_task(int unsigned ov, int unsigned t);
    if (!tk_used[ov][t]) begin
      tk_round_cnt[ov]++;
      tk_used[ov][t] = 1'b1;
    end
  endfunction

  function automatic int unsigned next_task(int unsigned ov, logic [RND_W-1:0] rnd,
                                            logic done, logic lost, logic fresh);
    int unsigned slot;
    int unsigned k;
    if (tk_round_cnt[ov] >= TASKS) begin
      tk_round_cnt[ov] = 0;
      tk_used[ov] = '0;
    end
    if (!done && lost) begin
      claim_task(ov, TASK_ATTEST);
      return TASK_ATTEST;
    end
    if (fresh && tk_turn[ov]) begin
      tk_turn[ov] = 1'b0;
      claim_task(ov, TASK_RECTIFY);
      return TASK_RECTIFY;
    end
    tk_turn[ov] = 1'b1;
    slot = rnd % TASKS;
    for (k = 0; k < TASKS && tk_used[ov][slot]; k++) slot = (slot + 1) % TASKS;
    if (k == TASKS) slot = rnd % TASKS;
    tk_round_cnt[ov]++;
    tk_used[ov][slot] = 1'b1;
    return slot;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_round_cnt = 0;
      foreach (ov_used[i]) ov_used[i] = 1'b0;
      foreach (tk_used[i]) begin
        tk_used[i]      = '0;
        tk_round_cnt[i] = 0;
        tk_turn[i]      = 1'b1;
      end
      chosen_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // result side first; a request never resolves in its own cycle
      if (out_valid_i && out_ready_i) begin
        if (chosen_q.size() == 0) begin
          $error("chosen: unexpected result %0d with nothing pending", chosen_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          chosen_exp = chosen_q.pop_front();
          if (chosen_i !== chosen_exp) begin
            $error("chosen mismatch: expected %0d, actual %0d", chosen_exp, chosen_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == PICK_OVERLAY)
          chosen_q.push_back(CHOSEN_W'(next_overlay(random_byte_i)));
        else
          chosen_q.push_back(CHOSEN_W'(next_task(overlay_i % OVERLAYS, random_byte_i,
                                                 attest_done_i, attest_lost_i,
                                                 rectify_new_i)));
      end
      pending_o <= chosen_q.size();
    end
  end

endmodule

// ----- bench/tb_randomized_round_scheduler.sv -----
`timescale 1ns / 100ps

module tb_randomized_round_scheduler;
  import rrs_pkg::*;
  import rrs_tb_pkg::*;

  localparam int unsigned OVERLAYS     = 8;
  localparam int unsigned RAND_ITEMS   = 1900;
  localparam int unsigned QUIET_ITEMS  = 250;   // tail of the run without idling
  localparam int unsigned HOLD_AT      = 500;   // random item that triggers the long stall
  localparam int unsigned DRAIN_AT     = 1000;  // random item preceded by a full drain
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 40;   // > worst-case request latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Request channel
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = 1'b0;
  logic [RND_W-1:0]    random_byte = '0;
  logic [OV_IN_W-1:0]  overlay = '0;
  logic                attest_done = 1'b0;
  logic                attest_lost = 1'b0;
  logic                rectify_new = 1'b0;

  // Result channel
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHOSEN_W-1:0] chosen;

  int  err_cnt;
  int  pending;
  bit  quiet = 1'b0;     // set for the tail: no idling on either side
  bit  hold_req = 1'b0;  // asks the receiver for one long stall

  always #1 clk = ~clk;

  randomized_round_scheduler #(
    .OVERLAYS(OVERLAYS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .random_byte_i (random_byte),
    .overlay_i     (overlay),
    .attest_done_i (attest_done),
    .attest_lost_i (attest_lost),
    .rectify_new_i (rectify_new),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .chosen_o      (chosen)
  );

  rrs_checker #(
    .OVERLAYS(OVERLAYS)
  ) u_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .random_byte_i (random_byte),
    .overlay_i     (overlay),
    .attest_done_i (attest_done),
    .attest_lost_i (attest_lost),
    .rectify_new_i (rectify_new),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .chosen_i      (chosen),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  // Present one request and hold it until the transfer. Returns at the edge of
  // the transfer, so the next request can follow with valid kept high.
  task automatic send_pick(pick_kind_e kind, logic [RND_W-1:0] rnd,
                           logic [OV_IN_W-1:0] ov, logic done, logic lost,
                           logic fresh);
    in_valid    <= 1'b1;
    action      <= kind;
    random_byte <= rnd;
    overlay     <= ov;
    attest_done <= done;
    attest_lost <= lost;
    rectify_new <= fresh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random idle burst on the request side, skipped in the quiet tail.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // pending is registered by the checker, hence the first edge before
  // looking at it.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random ready/stall bursts, one long stall on request, always
  // ready in the quiet tail.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Overlay round: extremes of the random byte, colliding start points
    // that force the circular probe, and a ninth pick that opens a new round.
    send_pick(PICK_OVERLAY, 8'd0,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd255, 3'd7, 1'b1, 1'b1, 1'b1); sender_gap();
    send_pick(PICK_OVERLAY, 8'd128, 3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd0,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd255, 3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd15,  3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd8,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'd9,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_OVERLAY, 8'h55,  3'd0, 1'b0, 1'b0, 1'b0); sender_gap();

    // Plain task round on overlay 0, then a full round that must clear.
    send_pick(PICK_TASK, 8'd0,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_TASK, 8'd0,   3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_TASK, 8'd255, 3'd0, 1'b0, 1'b0, 1'b0); sender_gap();
    send_pick(PICK_TASK, 8'd255, 3'd0, 1'b0, 1'b0, 1'b0); sender_gap();

    // Attest loss: forced task 2, repeated while already used, then
    // suppressed by attest_done.
    send_pick(PICK_TASK, 8'd1, 3'd1, 1'b0, 1'b1, 1'b0); sender_gap();
    send_pick(PICK_TASK, 8'd2, 3'd1, 1'b0, 1'b1, 1'b1); sender_gap();
    send_pick(PICK_TASK, 8'd2, 3'd1, 1'b1, 1'b1, 1'b0); sender_gap();

    // Rectify: forced task 1, then the alternate pick goes random and
    // re-arms the turn, then forced again on an already used task.
    send_pick(PICK_TASK, 8'd1, 3'd7, 1'b0, 1'b0, 1'b1); sender_gap();
    send_pick(PICK_TASK, 8'd0, 3'd7, 1'b0, 1'b0, 1'b1); sender_gap();
    send_pick(PICK_TASK, 8'd1, 3'd7, 1'b1, 1'b0, 1'b1); sender_gap();
    send_pick(PICK_TASK, 8'd2, 3'd7, 1'b1, 1'b0, 1'b1); sender_gap();
    send_pick(PICK_TASK, 8'd7, 3'd7, 1'b0, 1'b0, 1'b0); sender_gap();

    // Sender pause: let the block empty before the random part.
    drain();

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      // long receiver stall while requests keep coming: output register
      // fills, the block stops taking requests
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) drain();
      // attest loss about one in five, so normal picks dominate and rounds
      // actually fill up
      send_pick(pick_kind_e'($urandom_range(0, 1)), RND_W'($urandom),
                OV_IN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 4) == 0), 1'($urandom_range(0, 1)));
      sender_gap();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
